/* sv/fre_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package fre_pkg;

  localparam int unsigned REG_COUNT = 5;
  localparam int unsigned MEM_WORDS = 64;

  localparam int unsigned REG_AW = $clog2(REG_COUNT);
  localparam int unsigned MEM_AW = $clog2(MEM_WORDS);

  localparam int unsigned DATA_W = 32;
  localparam int unsigned BYTE_W = 8;
  localparam int unsigned IDX_W  = 6;
  localparam int unsigned PC_W   = 16;
  localparam int unsigned CVAL_W = 31;

  localparam logic [PC_W-1:0] PC_RESET = PC_W'(1);

  typedef enum logic [2:0] {
    ACT_MOV = 3'd0,
    ACT_ADD = 3'd1,
    ACT_SUB = 3'd2,
    ACT_JMP = 3'd3,
    ACT_JPN = 3'd4,
    ACT_PRN = 3'd5,
    ACT_HLT = 3'd6,
    ACT_BAD = 3'd7
  } action_e;

  typedef enum logic [1:0] {
    KIND_REG   = 2'd0,
    KIND_ADDR  = 2'd1,
    KIND_CONST = 2'd2,
    KIND_NONE  = 2'd3
  } kind_e;

  // operands and machine state seen by the execute unit
  typedef struct packed {
    action_e             action;
    logic                first_addr;
    logic [IDX_W-1:0]    fi;
    kind_e               kind;
    logic [IDX_W-1:0]    si;
    logic [CVAL_W-1:0]   cval;
    logic [PC_W-1:0]     target;
    logic [PC_W-1:0]     pc;
    logic                halted;
    logic [DATA_W-1:0]   ra;
    logic [DATA_W-1:0]   rb;
    logic [BYTE_W-1:0]   mv;
  } exec_in_t;

  // result transaction plus write-back requests
  typedef struct packed {
    logic [PC_W-1:0]     next_pc;
    logic                halted;
    logic                print_valid;
    logic [DATA_W-1:0]   print_value;
    logic                bad;
    logic                reg_we;
    logic [REG_AW-1:0]   reg_addr;
    logic [DATA_W-1:0]   reg_data;
    logic                mem_we;
    logic [MEM_AW-1:0]   mem_addr;
    logic [BYTE_W-1:0]   mem_data;
  } exec_out_t;

endpackage

`default_nettype wire

/* sv/fre_ram.sv */
`timescale 1ns / 1ps
`default_nettype none

module fre_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // read returns the old contents on a same-address write
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

/* sv/fre_exec.sv */
`timescale 1ns / 1ps
`default_nettype none

module fre_exec (
  input  wire fre_pkg::exec_in_t  x_i,
  output fre_pkg::exec_out_t      y_o
);

  logic [fre_pkg::DATA_W-1:0] mv32;
  logic [fre_pkg::DATA_W-1:0] cval32;
  logic [fre_pkg::DATA_W-1:0] src;
  logic [fre_pkg::DATA_W-1:0] alu;
  logic                       reg_req;
  logic [fre_pkg::IDX_W-1:0]  reg_idx;
  logic                       mem_req;
  logic [fre_pkg::IDX_W-1:0]  mem_idx;
  logic [fre_pkg::DATA_W-1:0] wdata;

  assign mv32   = {{(fre_pkg::DATA_W - fre_pkg::BYTE_W){1'b0}}, x_i.mv};
  assign cval32 = {1'b0, x_i.cval};

  always_comb begin
    unique case (x_i.kind)
      fre_pkg::KIND_REG:  src = x_i.rb;
      fre_pkg::KIND_ADDR: src = mv32;
      default:            src = cval32;
    endcase
  end

  assign alu = (x_i.action == fre_pkg::ACT_ADD) ? x_i.ra + src : x_i.ra - src;

  always_comb begin
    y_o             = '0;
    y_o.next_pc     = x_i.pc + fre_pkg::PC_W'(1);
    y_o.halted      = x_i.halted;
    reg_req         = 1'b0;
    reg_idx         = x_i.si;
    mem_req         = 1'b0;
    mem_idx         = x_i.si;
    wdata           = x_i.ra;
    if (x_i.halted) begin
      y_o.next_pc = x_i.pc;
    end else begin
      unique case (x_i.action)
        fre_pkg::ACT_MOV: begin
          if (!x_i.first_addr && x_i.kind == fre_pkg::KIND_REG) begin
            reg_req = 1'b1;
          end else if (!x_i.first_addr && x_i.kind == fre_pkg::KIND_ADDR) begin
            mem_req = 1'b1;
          end else if (!x_i.first_addr && x_i.kind == fre_pkg::KIND_CONST) begin
            reg_req = 1'b1;
            reg_idx = x_i.fi;
            wdata   = cval32;
          end else if (x_i.first_addr && x_i.kind == fre_pkg::KIND_REG) begin
            reg_req = 1'b1;
            wdata   = mv32;
          end else if (x_i.first_addr && x_i.kind == fre_pkg::KIND_CONST) begin
            mem_req = 1'b1;
            mem_idx = x_i.fi;
            wdata   = cval32;
          end
        end
        fre_pkg::ACT_ADD, fre_pkg::ACT_SUB: begin
          if (!x_i.first_addr && x_i.kind != fre_pkg::KIND_NONE) begin
            reg_req = 1'b1;
            reg_idx = x_i.fi;
            wdata   = alu;
          end
        end
        fre_pkg::ACT_JMP: begin
          if (x_i.kind == fre_pkg::KIND_NONE || x_i.ra == '0) begin
            y_o.next_pc = x_i.target;
          end
        end
        fre_pkg::ACT_JPN: begin
          if (x_i.ra == '0 || x_i.ra[fre_pkg::DATA_W-1]) begin
            y_o.next_pc = x_i.target;
          end
        end
        fre_pkg::ACT_PRN: begin
          y_o.print_valid = 1'b1;
          if (x_i.kind == fre_pkg::KIND_CONST) begin
            y_o.print_value = cval32;
          end else if (x_i.first_addr) begin
            y_o.print_value = mv32;
          end else begin
            y_o.print_value = x_i.ra;
          end
        end
        fre_pkg::ACT_HLT: begin
          y_o.halted = 1'b1;
        end
        fre_pkg::ACT_BAD: begin
          y_o.bad     = 1'b1;
          y_o.next_pc = x_i.pc;
        end
      endcase
    end
    // writes beyond the store are dropped
    y_o.reg_we   = reg_req && (32'(reg_idx) < fre_pkg::REG_COUNT);
    y_o.reg_addr = fre_pkg::REG_AW'(reg_idx);
    y_o.reg_data = wdata;
    y_o.mem_we   = mem_req && (32'(mem_idx) < fre_pkg::MEM_WORDS);
    y_o.mem_addr = fre_pkg::MEM_AW'(mem_idx);
    y_o.mem_data = wdata[fre_pkg::BYTE_W-1:0];
  end

endmodule

`default_nettype wire

/* sv/five_register_machine_execute.sv */
// Execute stage of a small register machine: each input transaction is one
// decoded instruction (MOV, ADD, SUB, JMP, JPN, PRN, HLT) and yields exactly
// one result transaction with the new PC, the halt flag, an optional print
// value and an error flag for an unknown action code. Sustained rate is one
// instruction per clock while the result side does not stall. An accepted
// instruction registers its register file and data memory reads together
// with itself in the execute slot, and execute then loads the output register
// from that slot. A stalled result holds the execute slot, and the input
// stalls in that same cycle. Registers live in two copies of a one-read RAM
// (one per source operand), the bytes in a third RAM. Write-back of the
// previous instruction is forwarded to the next one, so dependent
// instructions run back to back. Reset clears per-entry valid bits, so
// registers and memory read as zero after reset with no clear sweep.
// Register reads past the register count give all ones, memory reads past
// the end give zero, and such writes are dropped. After HLT, every
// instruction is answered with the held PC and nothing else changes.
`timescale 1ns / 1ps
`default_nettype none

module five_register_machine_execute (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               in_valid_i,
  output logic                                    in_stall_o,
  input  wire logic [2:0]                         action_i,
  input  wire logic                               first_is_address_i,
  input  wire logic [fre_pkg::IDX_W-1:0]          first_index_i,
  input  wire logic [1:0]                         second_kind_i,
  input  wire logic [fre_pkg::IDX_W-1:0]          second_index_i,
  input  wire logic [fre_pkg::CVAL_W-1:0]         constant_value_i,
  input  wire logic [fre_pkg::PC_W-1:0]           jump_target_i,
  output logic                                    out_valid_o,
  input  wire logic                               out_stall_i,
  output logic [fre_pkg::PC_W-1:0]                next_pc_o,
  output logic                                    halted_o,
  output logic                                    print_valid_o,
  output logic signed [fre_pkg::DATA_W-1:0]       print_value_o,
  output logic                                    bad_action_o
);

  // instruction held while its RAM reads are in flight
  typedef struct packed {
    fre_pkg::action_e             action;
    logic                         first_addr;
    logic [fre_pkg::IDX_W-1:0]    fi;
    fre_pkg::kind_e               kind;
    logic [fre_pkg::IDX_W-1:0]    si;
    logic [fre_pkg::CVAL_W-1:0]   cval;
    logic [fre_pkg::PC_W-1:0]     target;
    logic                         fi_ok;    // first index names a register
    logic                         si_ok;
    logic                         fi_vld;   // entry written since reset
    logic                         si_vld;
    logic                         mem_ok;   // byte address inside memory
    logic                         mem_vld;
    logic [fre_pkg::MEM_AW-1:0]   mem_addr;
  } s1_t;

  logic in_accept;
  logic s1_go;

  logic s1_valid_q;
  s1_t  s1_q, s1_d;

  logic [fre_pkg::PC_W-1:0] pc_q;
  logic                     halt_q;

  logic [fre_pkg::REG_COUNT-1:0] reg_vld_q;
  logic [fre_pkg::MEM_WORDS-1:0] mem_vld_q;

  // last write-back, covers the read that was issued in the same cycle
  logic                        fwd_reg_v_q;
  logic [fre_pkg::REG_AW-1:0]  fwd_reg_a_q;
  logic [fre_pkg::DATA_W-1:0]  fwd_reg_d_q;
  logic                        fwd_mem_v_q;
  logic [fre_pkg::MEM_AW-1:0]  fwd_mem_a_q;
  logic [fre_pkg::BYTE_W-1:0]  fwd_mem_d_q;

  logic [fre_pkg::REG_AW-1:0]  in_fi_ra;
  logic [fre_pkg::REG_AW-1:0]  in_si_ra;
  logic [fre_pkg::IDX_W-1:0]   in_mem_idx;
  logic [fre_pkg::MEM_AW-1:0]  in_mem_addr;
  fre_pkg::action_e            in_action;

  logic [fre_pkg::DATA_W-1:0]  rd_a;
  logic [fre_pkg::DATA_W-1:0]  rd_b;
  logic [fre_pkg::BYTE_W-1:0]  rd_m;

  logic [fre_pkg::REG_AW-1:0]  s1_fi_ra;
  logic [fre_pkg::REG_AW-1:0]  s1_si_ra;

  fre_pkg::exec_in_t  ex_in;
  fre_pkg::exec_out_t ex_out;

  logic                        out_valid_q;
  logic [fre_pkg::PC_W-1:0]    out_pc_q;
  logic                        out_halted_q;
  logic                        out_pvalid_q;
  logic [fre_pkg::DATA_W-1:0]  out_pvalue_q;
  logic                        out_bad_q;

  // ---------------------------------------------------------------------
  // Handshake: the execute slot drains into the output register whenever
  // that register is empty or its transaction is taken this cycle.
  // ---------------------------------------------------------------------
  assign s1_go      = s1_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = s1_valid_q && !s1_go;
  assign in_accept  = in_valid_i && !in_stall_o;

  // ---------------------------------------------------------------------
  // Read issue: register reads at both indices, one memory read. ADD and
  // SUB take a memory source from the second operand, all others read the
  // byte named by the first operand.
  // ---------------------------------------------------------------------
  assign in_action   = fre_pkg::action_e'(action_i);
  assign in_fi_ra    = fre_pkg::REG_AW'(first_index_i);
  assign in_si_ra    = fre_pkg::REG_AW'(second_index_i);
  assign in_mem_idx  = (in_action == fre_pkg::ACT_ADD || in_action == fre_pkg::ACT_SUB)
                       ? second_index_i : first_index_i;
  assign in_mem_addr = fre_pkg::MEM_AW'(in_mem_idx);

  always_comb begin
    s1_d            = '0;
    s1_d.action     = in_action;
    s1_d.first_addr = first_is_address_i;
    s1_d.fi         = first_index_i;
    s1_d.kind       = fre_pkg::kind_e'(second_kind_i);
    s1_d.si         = second_index_i;
    s1_d.cval       = constant_value_i;
    s1_d.target     = jump_target_i;
    s1_d.fi_ok      = 32'(first_index_i) < fre_pkg::REG_COUNT;
    s1_d.si_ok      = 32'(second_index_i) < fre_pkg::REG_COUNT;
    s1_d.mem_ok     = 32'(in_mem_idx) < fre_pkg::MEM_WORDS;
    s1_d.mem_addr   = in_mem_addr;
    // valid bits sampled alongside the RAM read; out-of-range never indexes
    s1_d.fi_vld     = s1_d.fi_ok && reg_vld_q[in_fi_ra];
    s1_d.si_vld     = s1_d.si_ok && reg_vld_q[in_si_ra];
    s1_d.mem_vld    = s1_d.mem_ok && mem_vld_q[in_mem_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_accept) begin
      s1_valid_q <= 1'b1;
    end else if (s1_go) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_q <= s1_d;
    end
  end

  // Register file, one copy per read port, both written together.
  fre_ram #(
    .WIDTH (fre_pkg::DATA_W),
    .DEPTH (fre_pkg::REG_COUNT)
  ) u_rf_a (
    .clk_i   (clk_i),
    .we_i    (s1_go && ex_out.reg_we),
    .waddr_i (ex_out.reg_addr),
    .wdata_i (ex_out.reg_data),
    .re_i    (in_accept),
    .raddr_i (in_fi_ra),
    .rdata_o (rd_a)
  );

  fre_ram #(
    .WIDTH (fre_pkg::DATA_W),
    .DEPTH (fre_pkg::REG_COUNT)
  ) u_rf_b (
    .clk_i   (clk_i),
    .we_i    (s1_go && ex_out.reg_we),
    .waddr_i (ex_out.reg_addr),
    .wdata_i (ex_out.reg_data),
    .re_i    (in_accept),
    .raddr_i (in_si_ra),
    .rdata_o (rd_b)
  );

  fre_ram #(
    .WIDTH (fre_pkg::BYTE_W),
    .DEPTH (fre_pkg::MEM_WORDS)
  ) u_dmem (
    .clk_i   (clk_i),
    .we_i    (s1_go && ex_out.mem_we),
    .waddr_i (ex_out.mem_addr),
    .wdata_i (ex_out.mem_data),
    .re_i    (in_accept),
    .raddr_i (in_mem_addr),
    .rdata_o (rd_m)
  );

  // ---------------------------------------------------------------------
  // Operand resolve: out of range first, then the bypass of the last
  // write-back, then the RAM word if the entry was ever written, else zero.
  // RAM outputs hold while the slot is stalled since reads fire on accept.
  // ---------------------------------------------------------------------
  assign s1_fi_ra = fre_pkg::REG_AW'(s1_q.fi);
  assign s1_si_ra = fre_pkg::REG_AW'(s1_q.si);

  always_comb begin
    ex_in            = '0;
    ex_in.action     = s1_q.action;
    ex_in.first_addr = s1_q.first_addr;
    ex_in.fi         = s1_q.fi;
    ex_in.kind       = s1_q.kind;
    ex_in.si         = s1_q.si;
    ex_in.cval       = s1_q.cval;
    ex_in.target     = s1_q.target;
    ex_in.pc         = pc_q;
    ex_in.halted     = halt_q;

    if (!s1_q.fi_ok) begin
      ex_in.ra = '1;
    end else if (fwd_reg_v_q && fwd_reg_a_q == s1_fi_ra) begin
      ex_in.ra = fwd_reg_d_q;
    end else if (s1_q.fi_vld) begin
      ex_in.ra = rd_a;
    end else begin
      ex_in.ra = '0;
    end

    if (!s1_q.si_ok) begin
      ex_in.rb = '1;
    end else if (fwd_reg_v_q && fwd_reg_a_q == s1_si_ra) begin
      ex_in.rb = fwd_reg_d_q;
    end else if (s1_q.si_vld) begin
      ex_in.rb = rd_b;
    end else begin
      ex_in.rb = '0;
    end

    if (!s1_q.mem_ok) begin
      ex_in.mv = '0;
    end else if (fwd_mem_v_q && fwd_mem_a_q == s1_q.mem_addr) begin
      ex_in.mv = fwd_mem_d_q;
    end else if (s1_q.mem_vld) begin
      ex_in.mv = rd_m;
    end else begin
      ex_in.mv = '0;
    end
  end

  fre_exec u_exec (
    .x_i (ex_in),
    .y_o (ex_out)
  );

  // ---------------------------------------------------------------------
  // Commit: PC, halt flag, valid bits and bypass registers move only when
  // the instruction leaves the execute slot.
  // ---------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q        <= fre_pkg::PC_RESET;
      halt_q      <= 1'b0;
      reg_vld_q   <= '0;
      mem_vld_q   <= '0;
      fwd_reg_v_q <= 1'b0;
      fwd_mem_v_q <= 1'b0;
    end else if (s1_go) begin
      pc_q        <= ex_out.next_pc;
      halt_q      <= ex_out.halted;
      fwd_reg_v_q <= ex_out.reg_we;
      fwd_mem_v_q <= ex_out.mem_we;
      if (ex_out.reg_we) begin
        reg_vld_q[ex_out.reg_addr] <= 1'b1;
      end
      if (ex_out.mem_we) begin
        mem_vld_q[ex_out.mem_addr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_go) begin
      fwd_reg_a_q <= ex_out.reg_addr;
      fwd_reg_d_q <= ex_out.reg_data;
      fwd_mem_a_q <= ex_out.mem_addr;
      fwd_mem_d_q <= ex_out.mem_data;
    end
  end

  // ---------------------------------------------------------------------
  // Output register
  // ---------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_go) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_go) begin
      out_pc_q     <= ex_out.next_pc;
      out_halted_q <= ex_out.halted;
      out_pvalid_q <= ex_out.print_valid;
      out_pvalue_q <= ex_out.print_value;
      out_bad_q    <= ex_out.bad;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign next_pc_o     = out_pc_q;
  assign halted_o      = out_halted_q;
  assign print_valid_o = out_pvalid_q;
  assign print_value_o = out_pvalue_q;
  assign bad_action_o  = out_bad_q;

endmodule

`default_nettype wire

/* sv/fre_checker.sv */
`timescale 1ns / 1ps
`default_nettype none

module fre_checker (
  input wire logic                               clk_i,
  input wire logic                               rst_ni,
  input wire logic                               out_valid_o,
  input wire logic                               out_stall_i,
  input wire logic [fre_pkg::PC_W-1:0]           next_pc_o,
  input wire logic                               halted_o,
  input wire logic                               print_valid_o,
  input wire logic signed [fre_pkg::DATA_W-1:0]  print_value_o,
  input wire logic                               bad_action_o
);

  logic                     out_take;
  logic                     seen_halt_q;
  logic [fre_pkg::PC_W-1:0] last_pc_q;

  assign out_take = out_valid_o && !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_halt_q <= 1'b0;
      last_pc_q   <= fre_pkg::PC_RESET;
    end else if (out_take) begin
      seen_halt_q <= seen_halt_q || halted_o;
      last_pc_q   <= next_pc_o;
    end
  end

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(next_pc_o) &&
    $stable(print_value_o) && $stable(halted_o))
    else $error("stalled result changed");

  // once halted, the machine is frozen
  a_halt_frozen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_take && seen_halt_q |-> halted_o && !print_valid_o && !bad_action_o &&
    print_value_o == '0 && next_pc_o == last_pc_q)
    else $error("activity after halt");

  a_no_print_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_take && !print_valid_o |-> print_value_o == '0)
    else $error("print value without print");

  // an unknown action leaves the PC where it was
  a_bad_holds_pc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_take && bad_action_o |-> !print_valid_o && !halted_o &&
    next_pc_o == last_pc_q)
    else $error("bad action moved the PC");

endmodule

bind five_register_machine_execute fre_checker u_fre_checker (.*);

`default_nettype wire

/* sim/testbench.sv */
`timescale 1ns / 1ps

module testbench;

  localparam int unsigned CYCLE_LIMIT  = 300000;
  localparam int unsigned RANDOM_ITEMS = 512;
  localparam int unsigned DRAIN_CYCLES = 10;   // results trail their instructions
  localparam int unsigned HOLD_START   = 150;  // transactions sent before the long stall
  localparam int unsigned HOLD_CYCLES  = 300;

  // One decoded instruction as it goes onto the input ports.
  typedef struct {
    fre_pkg::action_e                action;
    logic                            first_addr;
    logic [fre_pkg::IDX_W-1:0]       fi;
    fre_pkg::kind_e                  kind;
    logic [fre_pkg::IDX_W-1:0]       si;
    logic [fre_pkg::CVAL_W-1:0]      cval;
    logic [fre_pkg::PC_W-1:0]        target;
  } instr_t;

  // What the result channel must show for one instruction.
  typedef struct packed {
    logic [fre_pkg::PC_W-1:0]   next_pc;
    logic                       halted;
    logic                       print_valid;
    logic [fre_pkg::DATA_W-1:0] print_value;
    logic                       bad;
  } outcome_t;

  // DUT ports; every input has a known value from time zero.
  logic                              clk_i              = 1'b0;
  logic                              rst_ni             = 1'b0;
  logic                              in_valid_i         = 1'b0;
  logic                              in_stall_o;
  logic [2:0]                        action_i           = '0;
  logic                              first_is_address_i = 1'b0;
  logic [fre_pkg::IDX_W-1:0]         first_index_i      = '0;
  logic [1:0]                        second_kind_i      = '0;
  logic [fre_pkg::IDX_W-1:0]         second_index_i     = '0;
  logic [fre_pkg::CVAL_W-1:0]        constant_value_i   = '0;
  logic [fre_pkg::PC_W-1:0]          jump_target_i      = '0;
  logic                              out_valid_o;
  logic                              out_stall_i        = 1'b0;
  logic [fre_pkg::PC_W-1:0]          next_pc_o;
  logic                              halted_o;
  logic                              print_valid_o;
  logic signed [fre_pkg::DATA_W-1:0] print_value_o;
  logic                              bad_action_o;

  five_register_machine_execute dut (.*);

  // Shadow machine state, advanced once per accepted instruction.
  logic [fre_pkg::DATA_W-1:0] shadow_regs [fre_pkg::REG_COUNT];
  logic [fre_pkg::BYTE_W-1:0] shadow_mem  [fre_pkg::MEM_WORDS];
  logic [fre_pkg::PC_W-1:0]   shadow_pc;
  logic                       shadow_halt;

  instr_t   program_q [$];   // instructions still to be offered
  outcome_t outcome_q [$];   // results owed by the DUT, oldest first
  instr_t   offered;         // the instruction currently on the input ports

  int unsigned total_instrs;
  int unsigned sent_count;
  int unsigned cycle_count;
  int unsigned error_count;

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------
  // Shadow model of the execute stage
  // ---------------------------------------------------------------------

  // Out-of-range register numbers read as all ones and drop writes.
  function automatic logic [fre_pkg::DATA_W-1:0] reg_fetch(logic [fre_pkg::IDX_W-1:0] idx);
    if (idx < fre_pkg::REG_COUNT) return shadow_regs[idx];
    return '1;
  endfunction

  function automatic void reg_store(logic [fre_pkg::IDX_W-1:0] idx,
                                    logic [fre_pkg::DATA_W-1:0] v);
    if (idx < fre_pkg::REG_COUNT) shadow_regs[idx] = v;
  endfunction

  // Memory holds bytes: loads zero-extend, stores keep the low byte.
  function automatic logic [fre_pkg::DATA_W-1:0] mem_fetch(logic [fre_pkg::IDX_W-1:0] addr);
    if (addr < fre_pkg::MEM_WORDS) return {24'd0, shadow_mem[addr]};
    return '0;
  endfunction

  function automatic void mem_store(logic [fre_pkg::IDX_W-1:0] addr,
                                    logic [fre_pkg::DATA_W-1:0] v);
    if (addr < fre_pkg::MEM_WORDS) shadow_mem[addr] = v[fre_pkg::BYTE_W-1:0];
  endfunction

  function automatic outcome_t execute_instr(instr_t ins);
    outcome_t                   res;
    logic [fre_pkg::PC_W-1:0]   nxt;
    logic [fre_pkg::DATA_W-1:0] src;
    logic [fre_pkg::DATA_W-1:0] r;
    res = '0;
    // A halted machine only reports its held PC and the halt flag.
    if (shadow_halt) begin
      res.next_pc = shadow_pc;
      res.halted  = 1'b1;
      return res;
    end
    nxt = shadow_pc + 1'b1;   // wraps at 16 bits
    src = '0;
    case (ins.action)
      fre_pkg::ACT_MOV: begin
        // Combinations not listed here (address to address, absent
        // second operand) leave the state alone.
        if (!ins.first_addr && ins.kind == fre_pkg::KIND_REG)
          reg_store(ins.si, reg_fetch(ins.fi));
        else if (!ins.first_addr && ins.kind == fre_pkg::KIND_ADDR)
          mem_store(ins.si, reg_fetch(ins.fi));
        else if (!ins.first_addr && ins.kind == fre_pkg::KIND_CONST)
          reg_store(ins.fi, {1'b0, ins.cval});
        else if (ins.first_addr && ins.kind == fre_pkg::KIND_REG)
          reg_store(ins.si, mem_fetch(ins.fi));
        else if (ins.first_addr && ins.kind == fre_pkg::KIND_CONST)
          mem_store(ins.fi, {1'b0, ins.cval});
      end
      fre_pkg::ACT_ADD, fre_pkg::ACT_SUB: begin
        if (!ins.first_addr && ins.kind != fre_pkg::KIND_NONE) begin
          case (ins.kind)
            fre_pkg::KIND_REG:  src = reg_fetch(ins.si);
            fre_pkg::KIND_ADDR: src = mem_fetch(ins.si);
            default:            src = {1'b0, ins.cval};
          endcase
          r = reg_fetch(ins.fi);
          reg_store(ins.fi, (ins.action == fre_pkg::ACT_ADD) ? r + src : r - src);
        end
      end
      fre_pkg::ACT_JMP: begin
        if (ins.kind == fre_pkg::KIND_NONE || reg_fetch(ins.fi) == '0) nxt = ins.target;
      end
      fre_pkg::ACT_JPN: begin
        r = reg_fetch(ins.fi);
        if (r == '0 || r[fre_pkg::DATA_W-1]) nxt = ins.target;
      end
      fre_pkg::ACT_PRN: begin
        res.print_valid = 1'b1;
        if (ins.kind == fre_pkg::KIND_CONST) res.print_value = {1'b0, ins.cval};
        else if (ins.first_addr)             res.print_value = mem_fetch(ins.fi);
        else                                 res.print_value = reg_fetch(ins.fi);
      end
      fre_pkg::ACT_HLT: shadow_halt = 1'b1;
      default: begin
        // Unknown action: flag it, PC stays put.
        res.bad = 1'b1;
        nxt     = shadow_pc;
      end
    endcase
    shadow_pc   = nxt;
    res.next_pc = nxt;
    res.halted  = shadow_halt;
    return res;
  endfunction

  // ---------------------------------------------------------------------
  // Stimulus generation
  // ---------------------------------------------------------------------

  task automatic add_instr(fre_pkg::action_e a, logic fa, int unsigned fi,
                           fre_pkg::kind_e k, int unsigned si,
                           logic [fre_pkg::CVAL_W-1:0] c, logic [fre_pkg::PC_W-1:0] t);
    instr_t ins;
    ins.action     = a;
    ins.first_addr = fa;
    ins.fi         = fre_pkg::IDX_W'(fi);
    ins.kind       = k;
    ins.si         = fre_pkg::IDX_W'(si);
    ins.cval       = c;
    ins.target     = t;
    program_q.push_back(ins);
  endtask

  // Mostly valid register numbers so that values build up in the file.
  function automatic logic [fre_pkg::IDX_W-1:0] pick_reg();
    if ($urandom_range(99) < 90)
      return fre_pkg::IDX_W'($urandom_range(fre_pkg::REG_COUNT - 1));
    return fre_pkg::IDX_W'($urandom_range(63));
  endfunction

  function automatic logic [fre_pkg::CVAL_W-1:0] pick_const();
    case ($urandom_range(3))
      0:       return fre_pkg::CVAL_W'($urandom_range(15));
      1:       return {fre_pkg::CVAL_W{1'b1}} - fre_pkg::CVAL_W'($urandom_range(3));
      default: return fre_pkg::CVAL_W'($urandom);
    endcase
  endfunction

  // Well-formed instructions dominate; ignored combinations, bad register
  // numbers and the invalid action code make up the noise. HLT is kept
  // out of here since it freezes the machine for the rest of the run.
  function automatic instr_t random_instr();
    instr_t      ins;
    int unsigned roll;
    roll = $urandom_range(99);
    if      (roll < 25) ins.action = fre_pkg::ACT_MOV;
    else if (roll < 40) ins.action = fre_pkg::ACT_ADD;
    else if (roll < 55) ins.action = fre_pkg::ACT_SUB;
    else if (roll < 65) ins.action = fre_pkg::ACT_JMP;
    else if (roll < 75) ins.action = fre_pkg::ACT_JPN;
    else if (roll < 95) ins.action = fre_pkg::ACT_PRN;
    else                ins.action = fre_pkg::ACT_BAD;

    case (ins.action)
      fre_pkg::ACT_MOV:                   ins.first_addr = ($urandom_range(99) < 40);
      fre_pkg::ACT_ADD, fre_pkg::ACT_SUB: ins.first_addr = ($urandom_range(99) < 10);
      default:                            ins.first_addr = 1'($urandom);
    endcase
    ins.fi = ins.first_addr ? fre_pkg::IDX_W'($urandom_range(63)) : pick_reg();

    case (ins.action)
      fre_pkg::ACT_MOV, fre_pkg::ACT_ADD, fre_pkg::ACT_SUB:
        ins.kind = ($urandom_range(99) < 5) ? fre_pkg::KIND_NONE
                                            : fre_pkg::kind_e'(2'($urandom_range(2)));
      fre_pkg::ACT_JMP:
        ins.kind = ($urandom_range(99) < 30) ? fre_pkg::KIND_NONE
                                             : fre_pkg::kind_e'(2'($urandom_range(2)));
      default:
        ins.kind = fre_pkg::kind_e'(2'($urandom_range(3)));
    endcase
    ins.si     = (ins.kind == fre_pkg::KIND_ADDR) ? fre_pkg::IDX_W'($urandom_range(63))
                                                  : pick_reg();
    ins.cval   = pick_const();
    ins.target = ($urandom_range(99) < 5) ? {fre_pkg::PC_W{1'b1}}
                                          : fre_pkg::PC_W'($urandom_range(65535));
    return ins;
  endfunction

  // ---------------------------------------------------------------------
  // Idle rates: receiver slow first, then sender slow, then full speed
  // ---------------------------------------------------------------------

  function automatic int unsigned sender_idle_pct();
    if (sent_count < total_instrs / 3)     return 6;
    if (sent_count < 2 * total_instrs / 3) return 69;
    return 0;
  endfunction

  function automatic int unsigned receiver_idle_pct();
    if (sent_count < total_instrs / 3)     return 69;
    if (sent_count < 2 * total_instrs / 3) return 6;
    return 0;
  endfunction

  // ---------------------------------------------------------------------
  // Driver: offers instructions from program_q; a stalled transaction
  // holds its payload until the DUT takes it. Each accepted instruction
  // goes straight through the shadow model.
  // ---------------------------------------------------------------------

  always @(posedge clk_i) begin : drive_proc
    logic taken;
    if (rst_ni) begin
      taken = in_valid_i && !in_stall_o;
      if (taken) outcome_q.push_back(execute_instr(offered));

      if (in_valid_i && !taken) begin
        // stalled: keep everything as it is
      end else if (program_q.size() != 0 && $urandom_range(99) >= sender_idle_pct()) begin
        offered            = program_q.pop_front();
        action_i           <= offered.action;
        first_is_address_i <= offered.first_addr;
        first_index_i      <= offered.fi;
        second_kind_i      <= offered.kind;
        second_index_i     <= offered.si;
        constant_value_i   <= offered.cval;
        jump_target_i      <= offered.target;
        in_valid_i         <= 1'b1;
        sent_count++;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Monitor: checks each accepted result transaction against the oldest
  // owed outcome.
  // ---------------------------------------------------------------------

  task automatic compare_field(string field, logic [fre_pkg::DATA_W-1:0] want,
                               logic [fre_pkg::DATA_W-1:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %h actual %h", $time, field, want, got);
      error_count++;
    end
  endtask

  always @(posedge clk_i) begin : monitor_proc
    outcome_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (outcome_q.size() == 0) begin
        $display("%0t: result with none owed, expected nothing actual pc %h",
                 $time, next_pc_o);
        error_count++;
      end else begin
        want = outcome_q.pop_front();
        compare_field("next_pc", fre_pkg::DATA_W'(want.next_pc),
                      fre_pkg::DATA_W'(next_pc_o));
        compare_field("halted", fre_pkg::DATA_W'(want.halted),
                      fre_pkg::DATA_W'(halted_o));
        compare_field("print_valid", fre_pkg::DATA_W'(want.print_valid),
                      fre_pkg::DATA_W'(print_valid_o));
        compare_field("print_value", want.print_value, print_value_o);
        compare_field("bad_action", fre_pkg::DATA_W'(want.bad),
                      fre_pkg::DATA_W'(bad_action_o));
      end
    end
  end

  // ---------------------------------------------------------------------
  // Result-side stall, including one long hold-off that backs the
  // pipeline up into the input.
  // ---------------------------------------------------------------------

  always @(posedge clk_i) begin : stall_proc
    logic        stall_next;
    int unsigned hold_left;
    logic        hold_done;
    if (!rst_ni) begin
      hold_left = 0;
      hold_done = 1'b0;
    end else begin
      if (!hold_done && sent_count >= HOLD_START) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        hold_left--;
        stall_next = 1'b1;
      end else begin
        stall_next = ($urandom_range(99) < receiver_idle_pct());
      end
      out_stall_i <= stall_next;
    end
  end

  // Hard stop in case the DUT hangs.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // ---------------------------------------------------------------------
  // Program, reset and end of run
  // ---------------------------------------------------------------------

  initial begin
    for (int i = 0; i < fre_pkg::REG_COUNT; i++) shadow_regs[i] = '0;
    for (int i = 0; i < fre_pkg::MEM_WORDS; i++) shadow_mem[i] = '0;
    shadow_pc   = fre_pkg::PC_RESET;
    shadow_halt = 1'b0;

    // Directed part: reset values, wrap of registers and PC, all MOV
    // forms, byte truncation and zero extension, jumps taken and not,
    // out-of-range registers, ignored combinations, invalid action.
    add_instr(fre_pkg::ACT_PRN, 0, 0,  fre_pkg::KIND_REG,   0,  '0, '0);
    add_instr(fre_pkg::ACT_MOV, 0, 1,  fre_pkg::KIND_CONST, 0,  {fre_pkg::CVAL_W{1'b1}}, '0);
    add_instr(fre_pkg::ACT_ADD, 0, 1,  fre_pkg::KIND_CONST, 0,  fre_pkg::CVAL_W'(1), '0);
    add_instr(fre_pkg::ACT_PRN, 0, 1,  fre_pkg::KIND_REG,   0,  '0, '0);
    add_instr(fre_pkg::ACT_JPN, 0, 1,  fre_pkg::KIND_REG,   0,  '0, 16'hFFFF);
    add_instr(fre_pkg::ACT_SUB, 0, 2,  fre_pkg::KIND_CONST, 0,  fre_pkg::CVAL_W'(1), '0);
    add_instr(fre_pkg::ACT_ADD, 0, 2,  fre_pkg::KIND_CONST, 0,  fre_pkg::CVAL_W'(1), '0);
    add_instr(fre_pkg::ACT_JMP, 0, 2,  fre_pkg::KIND_REG,   0,  '0, 16'h0000);
    add_instr(fre_pkg::ACT_MOV, 0, 3,  fre_pkg::KIND_CONST, 0,  fre_pkg::CVAL_W'(32'h1FF), '0);
    add_instr(fre_pkg::ACT_MOV, 0, 3,  fre_pkg::KIND_ADDR,  63, '0, '0);
    add_instr(fre_pkg::ACT_MOV, 1, 63, fre_pkg::KIND_REG,   4,  '0, '0);
    add_instr(fre_pkg::ACT_PRN, 1, 63, fre_pkg::KIND_ADDR,  0,  '0, '0);
    add_instr(fre_pkg::ACT_MOV, 1, 0,  fre_pkg::KIND_CONST, 0,  {fre_pkg::CVAL_W{1'b1}}, '0);
    add_instr(fre_pkg::ACT_ADD, 0, 4,  fre_pkg::KIND_ADDR,  0,  '0, '0);
    add_instr(fre_pkg::ACT_SUB, 0, 4,  fre_pkg::KIND_REG,   3,  '0, '0);
    add_instr(fre_pkg::ACT_MOV, 0, 4,  fre_pkg::KIND_REG,   0,  '0, '0);
    add_instr(fre_pkg::ACT_PRN, 0, 63, fre_pkg::KIND_REG,   0,  '0, '0);
    add_instr(fre_pkg::ACT_MOV, 0, 0,  fre_pkg::KIND_REG,   63, '0, '0);
    add_instr(fre_pkg::ACT_ADD, 0, 7,  fre_pkg::KIND_CONST, 0,  fre_pkg::CVAL_W'(5), '0);
    add_instr(fre_pkg::ACT_ADD, 1, 3,  fre_pkg::KIND_CONST, 0,  fre_pkg::CVAL_W'(5), '0);
    add_instr(fre_pkg::ACT_MOV, 1, 0,  fre_pkg::KIND_ADDR,  1,  '0, '0);
    add_instr(fre_pkg::ACT_SUB, 0, 3,  fre_pkg::KIND_NONE,  0,  '0, '0);
    add_instr(fre_pkg::ACT_JMP, 0, 3,  fre_pkg::KIND_REG,   0,  '0, 16'h1234);
    add_instr(fre_pkg::ACT_JPN, 1, 3,  fre_pkg::KIND_CONST, 0,  '0, 16'h4321);
    add_instr(fre_pkg::ACT_JMP, 1, 63, fre_pkg::KIND_NONE,  63, '0, 16'hFFFF);
    add_instr(fre_pkg::ACT_PRN, 1, 5,  fre_pkg::KIND_CONST, 0,  {fre_pkg::CVAL_W{1'b1}}, '0);
    add_instr(fre_pkg::ACT_BAD, 1, 63, fre_pkg::KIND_NONE,  63, {fre_pkg::CVAL_W{1'b1}},
              16'hFFFF);

    for (int i = 0; i < RANDOM_ITEMS; i++) program_q.push_back(random_instr());

    // Halt last, then a few instructions that must change nothing.
    add_instr(fre_pkg::ACT_HLT, 0, 0, fre_pkg::KIND_NONE, 0, '0, '0);
    for (int i = 0; i < 10; i++) program_q.push_back(random_instr());
    total_instrs = program_q.size();

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    do @(posedge clk_i);
    while (program_q.size() != 0 || in_valid_i || outcome_q.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (error_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

/* five_register_machine_execute.f */
sv/fre_pkg.sv
sv/fre_ram.sv
sv/fre_exec.sv
sv/five_register_machine_execute.sv
sv/fre_checker.sv
sim/testbench.sv
